FILE: sv/weather_sensor_hub_slave_core_macros.svh
// Assertion macros for the weather sensor hub slave core.
// Included by the RTL file that carries concurrent checks; no other dependencies.
`ifndef WEATHER_SENSOR_HUB_SLAVE_CORE_MACROS_SVH
`define WEATHER_SENSOR_HUB_SLAVE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSHS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/wshs_pkg.sv
// Shared types, codes and helpers for the weather sensor hub slave core.
// No dependencies; compiled first.
package wshs_pkg;

    typedef enum logic [2:0] {
        ACT_PIN    = 3'd0,
        ACT_WINDOW = 3'd1,
        ACT_LOG    = 3'd2,
        ACT_LIGHT  = 3'd3,
        ACT_CMD    = 3'd4,
        ACT_READ   = 3'd5
    } t_action;

    localparam logic [7:0] CMD_BURST   = 8'h23;
    localparam logic [7:0] CMD_RAIN    = 8'h24;
    localparam logic [7:0] CMD_LASTPOS = 8'h21;
    localparam logic [7:0] CMD_READY   = 8'h01;
    localparam logic [7:0] CMD_CLEAR   = 8'hAA;
    localparam logic [7:0] BLOCK_MARK  = 8'hC0;
    localparam logic [7:0] BLOCK_MASK  = 8'h3F;
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // vane bands, inclusive
    localparam logic [9:0] SEC1_LO = 10'd70;
    localparam logic [9:0] SEC1_HI = 10'd116;
    localparam logic [9:0] SEC2_LO = 10'd163;
    localparam logic [9:0] SEC2_HI = 10'd209;
    localparam logic [9:0] SEC3_LO = 10'd318;
    localparam logic [9:0] SEC3_HI = 10'd364;
    localparam logic [9:0] SEC4_LO = 10'd489;
    localparam logic [9:0] SEC4_HI = 10'd535;

    function automatic logic [2:0] sector_of(input logic [9:0] s, input logic [2:0] old);
        logic [2:0] r;
        r = old;
        if (s >= SEC1_LO && s <= SEC1_HI) r = 3'd1;
        else if (s >= SEC2_LO && s <= SEC2_HI) r = 3'd2;
        else if (s >= SEC3_LO && s <= SEC3_HI) r = 3'd3;
        else if (s >= SEC4_LO && s <= SEC4_HI) r = 3'd4;
        return r;
    endfunction

endpackage

FILE: sv/wshs_if.sv
// Valid/ready channel interfaces for the weather sensor hub slave core.
// Standalone; used by the top level ports.
interface wshs_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic       wind_level;
    logic       rain_level;
    logic [9:0] direction_sample;
    logic [7:0] command_byte;

    modport source (output valid, action, wind_level, rain_level, direction_sample,
                    command_byte, input ready);
    modport sink   (input valid, action, wind_level, rain_level, direction_sample,
                    command_byte, output ready);
endinterface

interface wshs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

FILE: sv/weather_sensor_hub_slave_core.sv
// Weather sensor hub slave core: top level, sequencer and sensor state.
// Uses wshs_pkg, wshs_if.sv, wshs_log_ram and the assertion macro header.
//
// One item is taken at a time. Pin samples, window ends, lightning events and
// command writes finish in the cycle they are accepted. A log tick writes the
// speed byte at acceptance and the sector byte in state S_LOG2: both go through
// the single write port of the log memory one after the other. A read request
// sends its reply bytes one at a time (none for an unknown command, 1, 2 or 5
// for the short replies, BLOCK_BYTES (12 by default) for a log block); blocks
// stream one byte a cycle while the output is not stalled, because the memory
// read for the next byte is issued while the current one is handed out.
// The log reads as 0xFF after reset and after a clear command without any
// sweep of the memory: a fill mark records how much of the log has been
// written since, and bytes beyond it read as erased. No clearing pass runs.
`include "weather_sensor_hub_slave_core_macros.svh"

module weather_sensor_hub_slave_core import wshs_pkg::*; #(
    parameter int LOG_BYTES   = 384,
    parameter int BLOCK_BYTES = 12
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wshs_in_if.sink    i_in,
    wshs_out_if.source o_out
);

    localparam int AW  = $clog2(LOG_BYTES);
    localparam int WPW = $clog2(LOG_BYTES + 2);       // holds position + 2
    localparam int PW  = $clog2(64 * BLOCK_BYTES);    // any block byte position
    localparam int BIW = $clog2(BLOCK_BYTES);
    localparam logic [WPW-1:0] LOG_END  = WPW'(LOG_BYTES);
    localparam logic [PW-1:0]  BLK_SIZE = PW'(BLOCK_BYTES);
    localparam logic [BIW-1:0] BLK_LAST = BIW'(BLOCK_BYTES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOG2,
        S_BLK,
        S_SCAL
    } t_state;

    t_state         r_state;

    // sensor and command state
    logic [7:0]     r_cmd;
    logic [WPW-1:0] r_wp;
    logic [WPW-1:0] r_last_pos;
    logic [WPW-1:0] r_fill;       // log positions below this hold written data
    logic [7:0]     r_speed;
    logic [2:0]     r_sector;
    logic [15:0]    r_rain;
    logic [7:0]     r_lightning;
    logic           r_ready;
    logic [7:0]     r_win_wind;
    logic [7:0]     r_win_rain;
    logic           r_wind_high;
    logic           r_rain_high;

    // sequencer working registers
    logic [WPW-1:0] r_pend;       // second byte position of a log tick
    logic [PW-1:0]  r_blk_pos;
    logic [BIW-1:0] r_blk_idx;
    logic [2:0]     r_scal_idx;

    // output register
    logic           r_out_valid;
    logic [7:0]     r_out_data;
    logic           r_out_last;

    logic           in_acc;
    logic           out_free;
    logic           out_take;
    logic           out_load;
    logic           is_block;
    logic [PW-1:0]  blk_start;
    logic           blk_last;
    logic [PW-1:0]  blk_next;
    logic [WPW-1:0] wp_adv;
    logic [WPW-1:0] wp_cap;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;

    logic [7:0]     scal_byte;
    logic [2:0]     scal_len;
    logic           scal_known;

    assign i_in.ready      = (r_state == S_IDLE);
    assign in_acc          = i_in.valid && i_in.ready;
    assign out_free        = !r_out_valid || o_out.ready;
    assign out_take        = r_out_valid && o_out.ready;
    // a reply byte enters the output register this cycle
    assign out_load        = ((r_state == S_BLK) || (r_state == S_SCAL)) && out_free;
    assign o_out.valid     = r_out_valid;
    assign o_out.data_byte = r_out_data;
    assign o_out.last_byte = r_out_last;

    assign is_block  = ((r_cmd & BLOCK_MARK) == BLOCK_MARK);
    assign blk_start = PW'(r_cmd & BLOCK_MASK) * BLK_SIZE;
    assign blk_last  = (r_blk_idx == BLK_LAST);
    assign blk_next  = r_blk_pos + PW'(1);
    assign wp_adv    = r_wp + WPW'(2);
    assign wp_cap    = (wp_adv > LOG_END) ? LOG_END : wp_adv;

    // Log memory port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_speed;
        if (in_acc && i_in.action == ACT_LOG) begin
            ram_we    = (r_wp < LOG_END);
            ram_waddr = AW'(r_wp);
            ram_wdata = r_speed;
        end else if (r_state == S_LOG2) begin
            ram_we    = (r_pend < LOG_END);
            ram_waddr = AW'(r_pend);
            ram_wdata = {5'b0, r_sector};
        end
    end

    // Read one byte ahead: the first at acceptance, the next while handing one out.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (in_acc && i_in.action == ACT_READ && is_block) begin
            ram_re    = (blk_start < LOG_BYTES);
            ram_raddr = AW'(blk_start);
        end else if (r_state == S_BLK && out_free && !blk_last) begin
            ram_re    = (blk_next < LOG_BYTES);
            ram_raddr = AW'(blk_next);
        end
    end

    // Short replies: byte by index for the latched command.
    always_comb begin
        scal_byte  = CMD_CLEAR;
        scal_len   = 3'd1;
        scal_known = 1'b1;
        unique case (r_cmd)
            CMD_BURST: begin
                scal_len = 3'd5;
                case (r_scal_idx)
                    3'd0:    scal_byte = r_speed;
                    3'd1:    scal_byte = {5'b0, r_sector};
                    3'd2:    scal_byte = r_rain[7:0];
                    3'd3:    scal_byte = r_rain[15:8];
                    default: scal_byte = r_lightning;
                endcase
            end
            CMD_RAIN: begin
                scal_len  = 3'd2;
                scal_byte = (r_scal_idx == 3'd0) ? r_rain[7:0] : r_rain[15:8];
            end
            CMD_LASTPOS: begin
                scal_len  = 3'd2;
                scal_byte = (r_scal_idx == 3'd0) ? 8'(16'(r_last_pos))
                                                 : 8'(16'(r_last_pos) >> 8);
            end
            CMD_READY: begin
                scal_byte = {7'b0, r_ready};
            end
            CMD_CLEAR: begin
                scal_byte = CMD_CLEAR;
            end
            default: begin
                scal_known = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd       <= '0;
            r_wp        <= '0;
            r_last_pos  <= '0;
            r_fill      <= '0;
            r_speed     <= '0;
            r_sector    <= '0;
            r_rain      <= '0;
            r_lightning <= '0;
            r_ready     <= 1'b0;
            r_win_wind  <= '0;
            r_win_rain  <= '0;
            r_wind_high <= 1'b0;
            r_rain_high <= 1'b0;
            r_pend      <= '0;
            r_blk_pos   <= '0;
            r_blk_idx   <= '0;
            r_scal_idx  <= '0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
            r_out_last  <= 1'b0;
        end else begin
            if (out_take && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in.action)
                            ACT_PIN: begin
                                // falling edge = low after a high was seen
                                if (i_in.wind_level) begin
                                    r_wind_high <= 1'b1;
                                end else if (r_wind_high) begin
                                    r_wind_high <= 1'b0;
                                    r_win_wind  <= r_win_wind + 8'd1;
                                end
                                if (i_in.rain_level) begin
                                    r_rain_high <= 1'b1;
                                end else if (r_rain_high) begin
                                    r_rain_high <= 1'b0;
                                    r_win_rain  <= r_win_rain + 8'd1;
                                end
                            end
                            ACT_WINDOW: begin
                                r_sector    <= sector_of(i_in.direction_sample, r_sector);
                                r_speed     <= r_win_wind;
                                r_rain      <= r_rain + 16'(r_win_rain);
                                r_win_wind  <= '0;
                                r_win_rain  <= '0;
                                r_wind_high <= 1'b0;
                                r_rain_high <= 1'b0;
                            end
                            ACT_LOG: begin
                                // speed byte written this cycle, sector byte next
                                r_pend     <= r_wp + WPW'(1);
                                r_last_pos <= wp_adv;
                                r_wp       <= (wp_adv >= LOG_END) ? '0 : wp_adv;
                                if (wp_cap > r_fill) begin
                                    r_fill <= wp_cap;
                                end
                                r_ready    <= 1'b1;
                                r_speed    <= '0;
                                r_state    <= S_LOG2;
                            end
                            ACT_LIGHT: begin
                                r_lightning <= r_lightning + 8'd1;
                            end
                            ACT_CMD: begin
                                r_cmd <= i_in.command_byte;
                            end
                            ACT_READ: begin
                                if (is_block) begin
                                    r_blk_pos <= blk_start;
                                    r_blk_idx <= '0;
                                    r_state   <= S_BLK;
                                end else if (scal_known) begin
                                    r_scal_idx <= '0;
                                    r_state    <= S_SCAL;
                                    if (r_cmd == CMD_CLEAR) begin
                                        // erase by dropping the fill mark
                                        r_fill      <= '0;
                                        r_wp        <= '0;
                                        r_rain      <= '0;
                                        r_lightning <= '0;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_LOG2: begin
                    r_state <= S_IDLE;
                end
                S_BLK: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= (r_blk_pos < r_fill) ? ram_rdata : ERASED_BYTE;
                        r_out_last  <= blk_last;
                        if (blk_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_blk_pos <= blk_next;
                            r_blk_idx <= r_blk_idx + BIW'(1);
                        end
                    end
                end
                S_SCAL: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= scal_byte;
                        r_out_last  <= (r_scal_idx == scal_len - 3'd1);
                        if (r_scal_idx == scal_len - 3'd1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_scal_idx <= r_scal_idx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    wshs_log_ram #(
        .DEPTH (LOG_BYTES),
        .AW    (AW)
    ) u_log_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Fill mark never passes the log end, and the write pointer stays inside it.
    `WSHS_ASSERT_NOW(a_fill_bounds, i_clk, i_rst_n, 1'b1, (r_wp <= r_fill) && (r_fill <= LOG_END), "log fill mark out of bounds")
    // No memory write outside the log.
    `WSHS_ASSERT_NOW(a_write_in_range, i_clk, i_rst_n, ram_we, (ram_waddr < LOG_BYTES), "log write beyond capacity")
    // After the second log byte is written, the sequencer is back in S_IDLE on the next cycle.
    `WSHS_ASSERT_NEXT(a_log2_once, i_clk, i_rst_n, (r_state == S_LOG2), (r_state == S_IDLE), "log tick overran two cycles")
    // A read with a block command starts the block stream.
    `WSHS_ASSERT_NEXT(a_block_start, i_clk, i_rst_n, (in_acc && i_in.action == ACT_READ && is_block), (r_state == S_BLK && r_blk_idx == '0), "block read did not start")

endmodule

FILE: sv/wshs_log_ram.sv
// Log byte store: one write port, one read port, registered read data.
// No dependencies.
module wshs_log_ram #(
    parameter int DEPTH = 384,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
